// ===== hw/rtl/srrt_pkg.sv =====
// Package: shared types, sizes and codes for the scroll region row remap table.
package srrt_pkg;

   // Table geometry
   localparam int MAX_ROWS   = 64;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int CNT_W      = $clog2(MAX_ROWS + 1);
   localparam int RESET_ROWS = (24 <= MAX_ROWS) ? 24 : MAX_ROWS;

   // Command codes
   localparam logic [2:0] CMD_SCROLL_UP   = 3'd0;
   localparam logic [2:0] CMD_SCROLL_DOWN = 3'd1;
   localparam logic [2:0] CMD_CLEAR_ALL   = 3'd2;
   localparam logic [2:0] CMD_RESHAPE     = 3'd3;
   localparam logic [2:0] CMD_LOOKUP      = 3'd4;

   // Result action codes
   localparam logic [2:0] ACT_DONE   = 3'd0;
   localparam logic [2:0] ACT_CLEAR  = 3'd1;
   localparam logic [2:0] ACT_STORE  = 3'd2;
   localparam logic [2:0] ACT_FETCH  = 3'd3;
   localparam logic [2:0] ACT_LOOKUP = 3'd4;
   localparam logic [2:0] ACT_ERROR  = 3'd5;

   typedef struct packed {
      logic [2:0] cmd;
      logic [5:0] top;
      logic [5:0] bottom;
      logic [6:0] new_rows;
      logic [5:0] logical_row;
   } srrt_req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [5:0] phys_row;
      logic       last;
   } srrt_rsp_type;

endpackage

// ===== hw/rtl/srrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/scroll_region_row_remap_table.sv =====
// Top level: logical-to-physical row table with scroll, clear, reshape and lookup.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | srrt_req_type (cmd, rows, region)
//   rsp     | out       | rsp_valid/rsp_stall | srrt_rsp_type (action, phys_row, last)
//
// One transaction at a time; req_stall is high while a command is being worked.
// Scroll over [top,bottom]: reads the leaving row, then the one-read, one-write row table
//   RAM moves one entry per read/write pair and the freed row lands at the far end.
// Clear all, reshape grow: read and emit per row; lookup: one row; error, done: no read.
// Synchronous reset restores the identity map through per-entry valid bits at once.
// rsp_stall holds the output register; the sequencer waits on it before each result.
module scroll_region_row_remap_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  srrt_pkg::srrt_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output srrt_pkg::srrt_rsp_type rsp_data
);

   import srrt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FREE_RD,
      ST_FREE_USE,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_LAST_WR,
      ST_EMIT,
      ST_LIST_RD,
      ST_LIST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] ptr_ff, ptr_in;
   logic [ROW_W-1:0] end_ff, end_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [CNT_W-1:0] rows_ff, rows_in;
   logic             dir_up_ff, dir_up_in;
   logic [ROW_W-1:0] freed_ff, freed_in;
   logic [2:0]       pend_act_ff, pend_act_in;
   logic [2:0]       list_act_ff, list_act_in;
   logic             rsp_valid_ff, rsp_valid_in;
   srrt_rsp_type     rsp_data_ff, rsp_data_in;

   // Valid bits: an entry never written reads as its own index
   logic [MAX_ROWS-1:0] valid_ff;
   logic                rd_valid_ff;
   logic [ROW_W-1:0]    rd_addr_ff;

   logic             ram_wr_en, ram_rd_en;
   logic [ROW_W-1:0] ram_wr_addr, ram_rd_addr, ram_wr_data, ram_rd_data;
   logic [ROW_W-1:0] rval, src;
   logic             out_free, list_last;
   logic             scroll_bad;

   srrt_ram #(
      .WIDTH(ROW_W),
      .DEPTH(MAX_ROWS)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rval       = rd_valid_ff ? ram_rd_data : rd_addr_ff;
   assign src        = dir_up_ff ? ptr_ff + ROW_W'(1) : ptr_ff - ROW_W'(1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign list_last  = (CNT_W'(ptr_ff) + CNT_W'(1)) == lim_ff;
   assign scroll_bad = (req_data.bottom <= req_data.top) ||
                       (CNT_W'(req_data.bottom) >= rows_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      lim_in       = lim_ff;
      rows_in      = rows_ff;
      dir_up_in    = dir_up_ff;
      freed_in     = freed_ff;
      pend_act_in  = pend_act_ff;
      list_act_in  = list_act_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ptr_ff;
      ram_wr_data  = rval;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // default: single error result
               pend_act_in = ACT_ERROR;
               freed_in    = '0;
               state_in    = ST_EMIT;
               case (req_data.cmd)
                  CMD_SCROLL_UP, CMD_SCROLL_DOWN: begin
                     if (!scroll_bad) begin
                        dir_up_in = (req_data.cmd == CMD_SCROLL_UP);
                        if (req_data.cmd == CMD_SCROLL_UP) begin
                           ptr_in      = req_data.top;
                           end_in      = req_data.bottom;
                           pend_act_in = (req_data.top == '0) ? ACT_STORE : ACT_CLEAR;
                        end else begin
                           ptr_in      = req_data.bottom;
                           end_in      = req_data.top;
                           pend_act_in = (req_data.top == '0) ? ACT_FETCH : ACT_CLEAR;
                        end
                        state_in = ST_FREE_RD;
                     end
                  end
                  CMD_CLEAR_ALL: begin
                     if (rows_ff != '0) begin
                        ptr_in      = '0;
                        lim_in      = rows_ff;
                        list_act_in = ACT_CLEAR;
                        state_in    = ST_LIST_RD;
                     end
                  end
                  CMD_RESHAPE: begin
                     if (req_data.new_rows != '0 &&
                         req_data.new_rows <= CNT_W'(MAX_ROWS)) begin
                        rows_in = req_data.new_rows;
                        if (req_data.new_rows <= rows_ff) begin
                           pend_act_in = ACT_DONE;
                        end else begin
                           // rows_ff < new_rows <= MAX_ROWS, so it fits an index
                           ptr_in      = rows_ff[ROW_W-1:0];
                           lim_in      = req_data.new_rows;
                           list_act_in = ACT_CLEAR;
                           state_in    = ST_LIST_RD;
                        end
                     end
                  end
                  CMD_LOOKUP: begin
                     if (CNT_W'(req_data.logical_row) < rows_ff) begin
                        ptr_in      = req_data.logical_row;
                        lim_in      = CNT_W'(req_data.logical_row) + CNT_W'(1);
                        list_act_in = ACT_LOOKUP;
                        state_in    = ST_LIST_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // fetch the row that leaves the region
         ST_FREE_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_FREE_USE;
         end
         ST_FREE_USE: begin
            freed_in = rval;
            state_in = ST_MOVE_RD;
         end
         // shift one entry per read/write pair
         ST_MOVE_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = src;
            state_in    = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            ram_wr_en = 1'b1;
            ptr_in    = src;
            state_in  = (src == end_ff) ? ST_LAST_WR : ST_MOVE_RD;
         end
         // freed row lands at the far end of the region
         ST_LAST_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = freed_ff;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.action   = pend_act_ff;
               rsp_data_in.phys_row = freed_ff;
               rsp_data_in.last     = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         // walk a run of entries, one result each
         ST_LIST_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_LIST_EMIT;
         end
         ST_LIST_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.action   = list_act_ff;
               rsp_data_in.phys_row = rval;
               rsp_data_in.last     = list_last;
               if (list_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff + ROW_W'(1);
                  state_in = ST_LIST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, registered outputs and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= CNT_W'(RESET_ROWS);
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_wr_en) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
      end
      ptr_ff      <= ptr_in;
      end_ff      <= end_in;
      lim_ff      <= lim_in;
      dir_up_ff   <= dir_up_in;
      freed_ff    <= freed_in;
      pend_act_ff <= pend_act_in;
      list_act_ff <= list_act_in;
      rsp_data_ff <= rsp_data_in;
      if (ram_rd_en) begin
         rd_valid_ff <= valid_ff[ram_rd_addr];
         rd_addr_ff  <= ram_rd_addr;
      end
   end

   // Row count stays within the table
   a_rows_range: assert property (@(posedge clock) disable iff (reset)
      rows_ff != '0 && rows_ff <= CNT_W'(MAX_ROWS))
      else $error("row count out of range");

   // A shifting write never lands on the region end
   a_move_not_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOVE_WR |-> ptr_ff != end_ff)
      else $error("shift write at region end");

   // The freed row is written exactly at the region end
   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LAST_WR |-> ptr_ff == end_ff)
      else $error("freed row written off the region end");

   // Table writes only come from the rotate steps
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_MOVE_WR || state_ff == ST_LAST_WR))
      else $error("unexpected table write");

endmodule
